/* src/mfgql_pkg.sv */
`timescale 1ns / 1ps

package mfgql_pkg;

  // Pen position width
  localparam int unsigned POSITION_BITS_DEF = 32;
  // Extension width for signed compares and output clamps
  localparam int unsigned EXT_W = 64;

  // Control codes
  localparam logic [7:0] CODE_SPACE = 8'd32;
  localparam logic [7:0] CODE_TAB   = 8'd9;
  localparam logic [7:0] CODE_CR    = 8'd13;
  localparam logic [7:0] CODE_LF    = 8'd10;

  // Register indexes
  localparam logic [2:0] CFG_CODE_MAP     = 3'd0;
  localparam logic [2:0] CFG_GLYPH_BOX    = 3'd1;
  localparam logic [2:0] CFG_SPACE_WRAP   = 3'd2;
  localparam logic [2:0] CFG_ATLAS_ORIGIN = 3'd3;
  localparam logic [2:0] CFG_ATLAS_CELL   = 3'd4;

  localparam logic [31:0] CODE_MAP_RESET = 32'h0410_7E20;

  localparam logic [15:0] UV_MAX = 16'hFFFF;
  localparam int unsigned STEP_W = 17;
  localparam int unsigned PROD_W = 26;
  localparam int unsigned UVSUM_W = 27;

  typedef enum logic [2:0] {
    PEN_NONE,
    PEN_HOME,
    PEN_CR,
    PEN_ADV,
    PEN_LINE,
    PEN_TEST
  } pen_op_e;

  typedef struct packed {
    pen_op_e             op;
    logic [STEP_W-1:0]   step;
  } pen_cmd_t;

  function automatic logic [31:0] clamp32(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = EXT_W'(64'sd2147483647);
    lo = -hi - EXT_W'(64'sd1);
    if (v > hi) begin
      clamp32 = 32'h7FFF_FFFF;
    end else if (v < lo) begin
      clamp32 = 32'h8000_0000;
    end else begin
      clamp32 = v[31:0];
    end
  endfunction

  function automatic logic [15:0] sat16(input logic [UVSUM_W-1:0] v);
    if (v > UVSUM_W'(UV_MAX)) begin
      sat16 = UV_MAX;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

endpackage

/* src/mfgql_div.sv */
`timescale 1ns / 1ps

// Restoring 8-bit divider, one quotient bit per cycle.
// Zero divisor: quotient 0, remainder is the dividend.
module mfgql_div (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] dividend_i,
  input  logic [7:0] divisor_i,
  output logic [7:0] quo_o,
  output logic [7:0] rem_o,
  output logic       done_o
);

  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] quo_q, quo_d;
  logic [7:0] div_q, div_d;
  logic [8:0] shifted;
  logic       ge;
  logic [8:0] diff;

  assign shifted = {rem_q, quo_q[7]};
  assign ge      = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      div_d = divisor_i;
      cnt_d = 3'd0;
      if (divisor_i == 8'd0) begin
        rem_d  = dividend_i;
        quo_d  = 8'd0;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        rem_d  = 8'd0;
        quo_d  = dividend_i;
        busy_d = 1'b1;
        done_d = 1'b0;
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[7:0] : shifted[7:0];
      quo_d = {quo_q[6:0], ge};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

/* src/mfgql_pen.sv */
`timescale 1ns / 1ps

// Pen state with one shared saturating adder; one command per cycle.
module mfgql_pen #(
  parameter int unsigned POSITION_BITS = mfgql_pkg::POSITION_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mfgql_pkg::pen_cmd_t       cmd_i,
  input  logic [31:0]               limit_i,
  output logic [POSITION_BITS-1:0]  pen_x_o,
  output logic [POSITION_BITS-1:0]  pen_y_o,
  output logic                      wrap_o
);

  localparam int unsigned SW = POSITION_BITS + 2;

  logic [POSITION_BITS-1:0] x_q, x_d;
  logic [POSITION_BITS-1:0] y_q, y_d;
  logic                     wrap_q, wrap_d;
  logic signed [SW-1:0]     opa;
  logic signed [SW-1:0]     opb;
  logic signed [SW-1:0]     sum;
  logic [POSITION_BITS-1:0] sat;
  logic signed [mfgql_pkg::EXT_W-1:0] sum_ext;
  logic signed [mfgql_pkg::EXT_W-1:0] lim_ext;

  assign opa = (cmd_i.op == mfgql_pkg::PEN_LINE)
             ? SW'($signed(y_q)) : SW'($signed(x_q));
  assign opb = $signed({{(SW-mfgql_pkg::STEP_W){1'b0}}, cmd_i.step});
  assign sum = (cmd_i.op == mfgql_pkg::PEN_LINE) ? (opa - opb) : (opa + opb);

  // Fits when the top three bits agree; else clip by sign
  always_comb begin
    if (sum[SW-1:POSITION_BITS-1] == {3{sum[SW-1]}}) begin
      sat = sum[POSITION_BITS-1:0];
    end else if (sum[SW-1]) begin
      sat = {1'b1, {(POSITION_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(POSITION_BITS-1){1'b1}}};
    end
  end

  assign sum_ext = mfgql_pkg::EXT_W'(sum);
  assign lim_ext = $signed({{(mfgql_pkg::EXT_W-32){1'b0}}, limit_i});

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    wrap_d = wrap_q;
    case (cmd_i.op)
      mfgql_pkg::PEN_HOME: begin
        x_d = '0;
        y_d = '0;
      end
      mfgql_pkg::PEN_CR: begin
        x_d = '0;
      end
      mfgql_pkg::PEN_ADV: begin
        x_d = sat;
      end
      mfgql_pkg::PEN_LINE: begin
        x_d = '0;
        y_d = sat;
      end
      mfgql_pkg::PEN_TEST: begin
        wrap_d = (limit_i != 32'd0) && (sum_ext > lim_ext);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      wrap_q <= 1'b0;
    end else begin
      x_q    <= x_d;
      y_q    <= y_d;
      wrap_q <= wrap_d;
    end
  end

  assign pen_x_o = x_q;
  assign pen_y_o = y_q;
  assign wrap_o  = wrap_q;

endmodule

/* src/mono_font_glyph_quad_layout.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake                   Payload
// -------  ---------  --------------------------  -------------------------------------
// in       sink       in_valid_i / in_ready_o     char_code_i, text_start_i
// out      source     out_valid_o / out_ready_i   x_left_o .. y_top_o, u_low_o .. v_high_o
// cfg      sink       cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// Space, CR, LF and codes outside the glyph range go from idle through start and dispatch;
// a tab adds a test, wrap and advance step per tab stop; a printable glyph waits on the
// divider (done at once when glyphs per row is zero), then makes two passes through the shared multiplier.
// in_ready_o is high only while the sequencer is idle; one character at a time.
// A finished quad sits in the output register; if it is still held when the next
// glyph is ready, the sequencer waits there. cfg transfers are always taken.
// Reset clears the pen, the sequencer and the registers to their defaults.
module mono_font_glyph_quad_layout #(
  parameter int unsigned POSITION_BITS = mfgql_pkg::POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input characters
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        text_start_i,
  // output quads
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] x_left_o,
  output logic [31:0] y_bottom_o,
  output logic [31:0] x_right_o,
  output logic [31:0] y_top_o,
  output logic [15:0] u_low_o,
  output logic [15:0] v_low_o,
  output logic [15:0] u_high_o,
  output logic [15:0] v_high_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned EW = mfgql_pkg::EXT_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_TAB_TEST = 4'd3;
  localparam logic [3:0] S_TAB_WRAP = 4'd4;
  localparam logic [3:0] S_TAB_ADV  = 4'd5;
  localparam logic [3:0] S_G_TEST   = 4'd6;
  localparam logic [3:0] S_G_WRAP   = 4'd7;
  localparam logic [3:0] S_G_DIV    = 4'd8;
  localparam logic [3:0] S_G_MULU   = 4'd9;
  localparam logic [3:0] S_G_MULV   = 4'd10;
  localparam logic [3:0] S_G_OUT    = 4'd11;

  logic [3:0] state_q, state_d;

  // Configuration registers
  logic [31:0] code_map_q;
  logic [63:0] glyph_box_q;
  logic [47:0] space_wrap_q;
  logic [31:0] atlas_origin_q;
  logic [63:0] atlas_cell_q;

  // Per-character registers
  logic [7:0]  ch_q;
  logic        start_q;
  logic [7:0]  tab_cnt_q, tab_cnt_d;
  logic [mfgql_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [15:0] u_lo_q, u_lo_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] x_left_q, y_bottom_q, x_right_q, y_top_q;
  logic [15:0] u_low_q, v_low_q, u_high_q, v_high_q;
  logic        out_load;

  // Register fields
  logic [7:0]  first_code, last_code, per_row, tab_count;
  logic [15:0] glyph_w, glyph_h, gap_h, gap_line, space_w;
  logic [31:0] wrap_limit;
  logic [15:0] start_u, start_v, cell_u, cell_v, gap_u, gap_v;
  logic [mfgql_pkg::STEP_W-1:0] space_step, glyph_step, line_step;
  logic [mfgql_pkg::STEP_W-1:0] u_pitch, v_pitch;

  assign first_code = code_map_q[7:0];
  assign last_code  = code_map_q[15:8];
  assign per_row    = code_map_q[23:16];
  assign tab_count  = code_map_q[31:24];
  assign glyph_w    = glyph_box_q[15:0];
  assign glyph_h    = glyph_box_q[31:16];
  assign gap_h      = glyph_box_q[47:32];
  assign gap_line   = glyph_box_q[63:48];
  assign space_w    = space_wrap_q[15:0];
  assign wrap_limit = space_wrap_q[47:16];
  assign start_u    = atlas_origin_q[15:0];
  assign start_v    = atlas_origin_q[31:16];
  assign cell_u     = atlas_cell_q[15:0];
  assign cell_v     = atlas_cell_q[31:16];
  assign gap_u      = atlas_cell_q[47:32];
  assign gap_v      = atlas_cell_q[63:48];

  assign space_step = {1'b0, space_w} + {1'b0, gap_h};
  assign glyph_step = {1'b0, glyph_w} + {1'b0, gap_h};
  assign line_step  = {1'b0, glyph_h} + {1'b0, gap_line};
  assign u_pitch    = {1'b0, cell_u} + {1'b0, gap_u};
  assign v_pitch    = {1'b0, cell_v} + {1'b0, gap_v};

  // Register writes; indexes past the list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_map_q     <= mfgql_pkg::CODE_MAP_RESET;
      glyph_box_q    <= '0;
      space_wrap_q   <= '0;
      atlas_origin_q <= '0;
      atlas_cell_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mfgql_pkg::CFG_CODE_MAP:     code_map_q     <= cfg_data_i[31:0];
        mfgql_pkg::CFG_GLYPH_BOX:    glyph_box_q    <= cfg_data_i;
        mfgql_pkg::CFG_SPACE_WRAP:   space_wrap_q   <= cfg_data_i[47:0];
        mfgql_pkg::CFG_ATLAS_ORIGIN: atlas_origin_q <= cfg_data_i[31:0];
        mfgql_pkg::CFG_ATLAS_CELL:   atlas_cell_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Character classes; controls win over the glyph range
  logic is_space, is_tab, is_cr, is_lf, is_glyph;
  assign is_space = ch_q == mfgql_pkg::CODE_SPACE;
  assign is_tab   = ch_q == mfgql_pkg::CODE_TAB;
  assign is_cr    = ch_q == mfgql_pkg::CODE_CR;
  assign is_lf    = ch_q == mfgql_pkg::CODE_LF;
  assign is_glyph = (ch_q >= first_code) && (ch_q <= last_code);

  // Pen unit
  mfgql_pkg::pen_cmd_t      pen_cmd;
  logic [POSITION_BITS-1:0] pen_x, pen_y;
  logic                     wrap_hit;

  mfgql_pen #(
    .POSITION_BITS(POSITION_BITS)
  ) u_pen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (pen_cmd),
    .limit_i (wrap_limit),
    .pen_x_o (pen_x),
    .pen_y_o (pen_y),
    .wrap_o  (wrap_hit)
  );

  // Atlas row and column
  logic       div_start;
  logic [7:0] row, col;
  logic       div_done;

  mfgql_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ch_q - first_code),
    .divisor_i  (per_row),
    .quo_o      (row),
    .rem_o      (col),
    .done_o     (div_done)
  );

  // Shared multiplier: column * u pitch, then (row + 1) * v pitch
  logic [8:0]                    mul_a;
  logic [mfgql_pkg::STEP_W-1:0]  mul_b;
  logic [mfgql_pkg::PROD_W-1:0]  mul_p;

  assign mul_a = (state_q == S_G_MULV) ? ({1'b0, row} + 9'd1) : {1'b0, col};
  assign mul_b = (state_q == S_G_MULV) ? v_pitch : u_pitch;
  assign mul_p = mfgql_pkg::PROD_W'(mul_a) * mfgql_pkg::PROD_W'(mul_b);

  // uv from the products
  logic [mfgql_pkg::UVSUM_W-1:0] u_sum, v_sum;
  logic [15:0] v_lo;

  assign u_sum = mfgql_pkg::UVSUM_W'(start_u) + mfgql_pkg::UVSUM_W'(prod_q);
  assign v_sum = mfgql_pkg::UVSUM_W'(start_v) + mfgql_pkg::UVSUM_W'(prod_q);

  // v = 1.0 - sum, clamped to [0, 1.0 - lsb]
  always_comb begin
    if (v_sum == '0) begin
      v_lo = mfgql_pkg::UV_MAX;
    end else if (v_sum[mfgql_pkg::UVSUM_W-1:16] != '0) begin
      v_lo = 16'd0;
    end else begin
      v_lo = 16'd0 - v_sum[15:0];
    end
  end

  // Screen edges from the pen
  logic signed [EW-1:0] pen_x_ext, pen_y_ext;
  assign pen_x_ext = EW'($signed(pen_x));
  assign pen_y_ext = EW'($signed(pen_y));

  assign out_load = (state_q == S_G_OUT) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    tab_cnt_d    = tab_cnt_q;
    prod_d       = prod_q;
    u_lo_d       = u_lo_q;
    div_start    = 1'b0;
    pen_cmd.op   = mfgql_pkg::PEN_NONE;
    pen_cmd.step = space_step;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_START;
        end
      end
      S_START: begin
        if (start_q) begin
          pen_cmd.op = mfgql_pkg::PEN_HOME;
        end
        state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_d = S_IDLE;
        if (is_space) begin
          pen_cmd.op = mfgql_pkg::PEN_ADV;
        end else if (is_tab) begin
          tab_cnt_d = tab_count;
          if (tab_count != 8'd0) begin
            state_d = S_TAB_TEST;
          end
        end else if (is_cr) begin
          pen_cmd.op = mfgql_pkg::PEN_CR;
        end else if (is_lf) begin
          pen_cmd.op   = mfgql_pkg::PEN_LINE;
          pen_cmd.step = line_step;
        end else if (!is_glyph) begin
          pen_cmd.op = mfgql_pkg::PEN_ADV;
        end else begin
          div_start = 1'b1;
          state_d   = S_G_TEST;
        end
      end
      S_TAB_TEST: begin
        pen_cmd.op   = mfgql_pkg::PEN_TEST;
        pen_cmd.step = {1'b0, glyph_w};
        state_d      = S_TAB_WRAP;
      end
      S_TAB_WRAP: begin
        if (wrap_hit) begin
          pen_cmd.op   = mfgql_pkg::PEN_LINE;
          pen_cmd.step = line_step;
        end
        state_d = S_TAB_ADV;
      end
      S_TAB_ADV: begin
        pen_cmd.op = mfgql_pkg::PEN_ADV;
        tab_cnt_d  = tab_cnt_q - 8'd1;
        state_d    = (tab_cnt_q == 8'd1) ? S_IDLE : S_TAB_TEST;
      end
      S_G_TEST: begin
        pen_cmd.op   = mfgql_pkg::PEN_TEST;
        pen_cmd.step = {1'b0, glyph_w};
        state_d      = S_G_WRAP;
      end
      S_G_WRAP: begin
        if (wrap_hit) begin
          pen_cmd.op   = mfgql_pkg::PEN_LINE;
          pen_cmd.step = line_step;
        end
        state_d = S_G_DIV;
      end
      S_G_DIV: begin
        if (div_done) begin
          state_d = S_G_MULU;
        end
      end
      S_G_MULU: begin
        prod_d  = mul_p;
        state_d = S_G_MULV;
      end
      S_G_MULV: begin
        u_lo_d  = mfgql_pkg::sat16(u_sum);
        prod_d  = mul_p;
        state_d = S_G_OUT;
      end
      S_G_OUT: begin
        // quad is taken from the pen before this advance lands
        if (out_load) begin
          pen_cmd.op   = mfgql_pkg::PEN_ADV;
          pen_cmd.step = glyph_step;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tab_cnt_q   <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tab_cnt_q   <= tab_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q    <= char_code_i;
      start_q <= text_start_i;
    end
    prod_q <= prod_d;
    u_lo_q <= u_lo_d;
    if (out_load) begin
      x_left_q   <= mfgql_pkg::clamp32(pen_x_ext);
      y_bottom_q <= mfgql_pkg::clamp32(pen_y_ext);
      x_right_q  <= mfgql_pkg::clamp32(pen_x_ext + EW'(glyph_w));
      y_top_q    <= mfgql_pkg::clamp32(pen_y_ext + EW'(glyph_h));
      u_low_q    <= u_lo_q;
      v_low_q    <= v_lo;
      u_high_q   <= mfgql_pkg::sat16(mfgql_pkg::UVSUM_W'(u_lo_q)
                                     + mfgql_pkg::UVSUM_W'(cell_u));
      v_high_q   <= mfgql_pkg::sat16(mfgql_pkg::UVSUM_W'(v_lo)
                                     + mfgql_pkg::UVSUM_W'(cell_v));
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_left_o    = x_left_q;
  assign y_bottom_o  = y_bottom_q;
  assign x_right_o   = x_right_q;
  assign y_top_o     = y_top_q;
  assign u_low_o     = u_low_q;
  assign v_low_o     = v_low_q;
  assign u_high_o    = u_high_q;
  assign v_high_o    = v_high_q;

endmodule

/* tb/mono_font_glyph_quad_layout_test.sv */
`timescale 1ns / 1ps

// Checks the glyph quad layout block against its own layout predictor.
// One queue holds the planned characters, register writes and pauses. The driver
// plays it onto the char and cfg channels. The monitor predicts a quad for every
// accepted printable glyph and compares each output transfer against the oldest one.
module mono_font_glyph_quad_layout_test;

  localparam int PEN_W = mfgql_pkg::POSITION_BITS_DEF;
  // A tab at tab count 255 runs test, wrap and advance for each stop: the longest
  // stretch with no result, so it sets how long to settle before a register write.
  localparam int SETTLE_CYCLES = 800;
  localparam int TAIL_CYCLES = 800;
  localparam longint RUN_LIMIT_NS = 64'd60_000_000;
  localparam int RANDOM_PHASES = 9;

  typedef enum logic [1:0] {ENT_CHAR, ENT_REG, ENT_PAUSE} entry_kind_e;

  typedef struct packed {
    entry_kind_e kind;
    logic [7:0]  code;
    logic        restart;
    logic [2:0]  reg_index;
    logic [63:0] reg_data;
    logic [15:0] pause;
    logic        calm;
  } entry_t;

  typedef struct packed {
    logic [31:0] x_left;
    logic [31:0] y_bottom;
    logic [31:0] x_right;
    logic [31:0] y_top;
    logic [15:0] u_low;
    logic [15:0] v_low;
    logic [15:0] u_high;
    logic [15:0] v_high;
  } quad_t;

  // DUT connections: every input has a known value from time zero
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i = '0;
  logic        text_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic [31:0] x_left_o;
  logic [31:0] y_bottom_o;
  logic [31:0] x_right_o;
  logic [31:0] y_top_o;
  logic [15:0] u_low_o;
  logic [15:0] v_low_o;
  logic [15:0] u_high_o;
  logic [15:0] v_high_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  // Stimulus plan and run bookkeeping
  entry_t todo_q[$];
  quad_t  quads_due[$];
  logic   calm = 1'b0;       // set near the end: no idling on either side
  logic   calm_fill = 1'b0;  // build-time flag stamped onto queued entries
  logic   feed_done = 1'b0;
  int     due_count = 0;
  int     gap_left = 0;
  int     pause_left = 0;
  logic   pausing = 1'b0;
  int     hold = 0;
  int     fails = 0;
  int     chars_done = 0;
  int     quads_seen = 0;
  int     settings_used = 1;

  // Predictor copy of the registers and the pen
  logic [31:0]            map_r = mfgql_pkg::CODE_MAP_RESET;
  logic [63:0]            box_r = '0;
  logic [47:0]            space_wrap_r = '0;
  logic [31:0]            origin_r = '0;
  logic [63:0]            cell_r = '0;
  logic signed [PEN_W-1:0] pen_x = '0;
  logic signed [PEN_W-1:0] pen_y = '0;

  mono_font_glyph_quad_layout uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .text_start_i (text_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .x_left_o     (x_left_o),
    .y_bottom_o   (y_bottom_o),
    .x_right_o    (x_right_o),
    .y_top_o      (y_top_o),
    .u_low_o      (u_low_o),
    .v_low_o      (v_low_o),
    .u_high_o     (u_high_o),
    .v_high_o     (v_high_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Layout predictor
  // ---------------------------------------------------------------------------

  // Pen updates saturate to the signed pen width
  function automatic logic signed [PEN_W-1:0] pen_clip(input longint v);
    longint top;
    top = (longint'(1) <<< (PEN_W - 1)) - 1;
    if (v > top) return PEN_W'(top);
    if (v < -top - 1) return PEN_W'(-top - 1);
    return PEN_W'(v);
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // uv values: saturate high, clamp negative to zero
  function automatic logic [15:0] clip16(input longint v);
    if (v > 65535) return 16'hFFFF;
    if (v < 0) return 16'h0000;
    return v[15:0];
  endfunction

  // CR plus a step down by glyph height and line gap
  task automatic drop_line();
    longint gh, lg, py;
    gh = box_r[31:16];
    lg = box_r[63:48];
    py = pen_y;
    pen_x = '0;
    pen_y = pen_clip(py - gh - lg);
  endtask

  // Signed compare against the limit; a zero limit means no wrapping
  task automatic wrap_guard();
    longint lim, gw, px;
    lim = space_wrap_r[47:16];
    gw = box_r[15:0];
    px = pen_x;
    if (lim != 0 && px + gw > lim) drop_line();
  endtask

  task automatic space_move();
    longint sw, hg, px;
    sw = space_wrap_r[15:0];
    hg = box_r[47:32];
    px = pen_x;
    pen_x = pen_clip(px + sw + hg);
  endtask

  task automatic store_reg(input logic [2:0] idx, input logic [63:0] data);
    case (idx)
      mfgql_pkg::CFG_CODE_MAP:     map_r = data[31:0];
      mfgql_pkg::CFG_GLYPH_BOX:    box_r = data;
      mfgql_pkg::CFG_SPACE_WRAP:   space_wrap_r = data[47:0];
      mfgql_pkg::CFG_ATLAS_ORIGIN: origin_r = data[31:0];
      mfgql_pkg::CFG_ATLAS_CELL:   cell_r = data;
      default: ;
    endcase
  endtask

  // One character: moves the pen, and for a printable glyph builds its quad
  task automatic layout_char(input logic [7:0] code, input logic restart,
                             output quad_t q, output bit emits);
    longint c, first, last, per_row, tabs, k, gw, gh, hg, idx, row, col;
    longint cu, cv, step_u, step_v, ulo, vlo, px, py;
    c = code;
    first = map_r[7:0];
    last = map_r[15:8];
    per_row = map_r[23:16];
    tabs = map_r[31:24];
    gw = box_r[15:0];
    gh = box_r[31:16];
    hg = box_r[47:32];
    emits = 1'b0;
    q = '0;
    if (restart) begin
      pen_x = '0;
      pen_y = '0;
    end
    // control codes win even inside the glyph range
    if (code == mfgql_pkg::CODE_SPACE) begin
      space_move();
    end else if (code == mfgql_pkg::CODE_TAB) begin
      for (k = 0; k < tabs; k++) begin
        wrap_guard();
        space_move();
      end
    end else if (code == mfgql_pkg::CODE_CR) begin
      pen_x = '0;
    end else if (code == mfgql_pkg::CODE_LF) begin
      drop_line();
    end else if (c < first || c > last) begin
      // also covers an empty range (first above last)
      space_move();
    end else begin
      wrap_guard();
      idx = c - first;
      if (per_row == 0) begin
        row = 0;
        col = idx;
      end else begin
        row = idx / per_row;
        col = idx % per_row;
      end
      cu = cell_r[15:0];
      cv = cell_r[31:16];
      step_u = cu + longint'(cell_r[47:32]);
      step_v = cv + longint'(cell_r[63:48]);
      ulo = clip16(longint'(origin_r[15:0]) + col * step_u);
      vlo = clip16(65536 - (longint'(origin_r[31:16]) + (row + 1) * step_v));
      px = pen_x;
      py = pen_y;
      q.x_left = clip32(px);
      q.y_bottom = clip32(py);
      q.x_right = clip32(px + gw);
      q.y_top = clip32(py + gh);
      q.u_low = ulo[15:0];
      q.v_low = vlo[15:0];
      q.u_high = clip16(ulo + cu);
      q.v_high = clip16(vlo + cv);
      pen_x = pen_clip(px + gw + hg);
      emits = 1'b1;
    end
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= 10)
        $display("%t quad %0d %s: expected %h, got %h", $time, quads_seen, label, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: plays the plan, one entry at a time. in_valid_i and cfg_valid_i each
  // get a single nonblocking write per edge, so back to back transfers keep
  // valid high without a glitch.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : feed
    entry_t e;
    logic   nxt_in, nxt_cfg;
    nxt_in = in_valid_i;
    nxt_cfg = cfg_valid_i;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o)) begin
        nxt_in = 1'b0;
        nxt_cfg = 1'b0;
        // random idle burst before the next transfer
        if (!calm && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 5);
      end
      if (!nxt_in && !nxt_cfg) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pausing) begin
          // hold off until every predicted quad is back, then settle
          if (due_count == 0) begin
            if (pause_left != 0) pause_left--;
            else pausing = 1'b0;
          end
        end else if (todo_q.size() != 0) begin
          e = todo_q.pop_front();
          calm <= e.calm;
          case (e.kind)
            ENT_CHAR: begin
              nxt_in = 1'b1;
              char_code_i <= e.code;
              text_start_i <= e.restart;
            end
            ENT_REG: begin
              nxt_cfg = 1'b1;
              cfg_index_i <= e.reg_index;
              cfg_data_i <= e.reg_data;
            end
            default: begin
              pausing = 1'b1;
              pause_left = e.pause;
            end
          endcase
        end else begin
          feed_done <= 1'b1;
        end
      end
    end
    in_valid_i <= nxt_in;
    cfg_valid_i <= nxt_cfg;
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks output transfers, then predicts from the input transfers of
  // the same edge, and drives the random stalls on out_ready_i.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    quad_t q;
    bit    emits;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        quads_seen++;
        if (quads_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%t quad out with none predicted: x %h y %h u %h v %h", $time,
                     x_left_o, y_bottom_o, u_low_o, v_low_o);
        end else begin
          q = quads_due.pop_front();
          check_field("x_left", q.x_left, x_left_o);
          check_field("y_bottom", q.y_bottom, y_bottom_o);
          check_field("x_right", q.x_right, x_right_o);
          check_field("y_top", q.y_top, y_top_o);
          check_field("u_low", 32'(q.u_low), 32'(u_low_o));
          check_field("v_low", 32'(q.v_low), 32'(v_low_o));
          check_field("u_high", 32'(q.u_high), 32'(u_high_o));
          check_field("v_high", 32'(q.v_high), 32'(v_high_o));
        end
      end
      if (cfg_valid_i && cfg_ready_o) store_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        layout_char(char_code_i, text_start_i, q, emits);
        chars_done++;
        if (emits) quads_due = {quads_due, q};
      end
      due_count <= quads_due.size();
      if (hold != 0) hold--;
      else if (!calm && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 5);
      out_ready_i <= (hold == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Plan building
  // ---------------------------------------------------------------------------
  task automatic add_char(input logic [7:0] code, input logic restart);
    entry_t e;
    e = '0;
    e.kind = ENT_CHAR;
    e.code = code;
    e.restart = restart;
    e.calm = calm_fill;
    todo_q = {todo_q, e};
  endtask

  task automatic add_pause(input int cycles);
    entry_t e;
    e = '0;
    e.kind = ENT_PAUSE;
    e.pause = 16'(cycles);
    e.calm = calm_fill;
    todo_q = {todo_q, e};
  endtask

  task automatic add_reg(input logic [2:0] idx, input logic [63:0] data);
    entry_t e;
    e = '0;
    e.kind = ENT_REG;
    e.reg_index = idx;
    e.reg_data = data;
    e.calm = calm_fill;
    todo_q = {todo_q, e};
  endtask

  // New register set, written only once the block has gone quiet.
  // Bits above each register's width carry junk that must be ignored.
  task automatic program_all(input logic [31:0] cm, input logic [63:0] gb,
                             input logic [47:0] sw, input logic [31:0] ao,
                             input logic [63:0] ac);
    add_pause(SETTLE_CYCLES);
    add_reg(mfgql_pkg::CFG_CODE_MAP, {32'($urandom), cm});
    add_reg(mfgql_pkg::CFG_GLYPH_BOX, gb);
    add_reg(mfgql_pkg::CFG_SPACE_WRAP, {16'($urandom), sw});
    add_reg(mfgql_pkg::CFG_ATLAS_ORIGIN, {32'($urandom), ao});
    add_reg(mfgql_pkg::CFG_ATLAS_CELL, ac);
    settings_used++;
  endtask

  // Running text: mostly glyphs from the active range, with controls mixed in
  task automatic add_text(input int count, input logic [31:0] cm, input int tab_pct);
    int i, r, lo, hi;
    logic [7:0] code;
    lo = cm[7:0];
    hi = cm[15:8];
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < tab_pct) code = mfgql_pkg::CODE_TAB;
      else if (r < tab_pct + 10) code = mfgql_pkg::CODE_SPACE;
      else if (r < tab_pct + 15) code = mfgql_pkg::CODE_CR;
      else if (r < tab_pct + 20) code = mfgql_pkg::CODE_LF;
      else if (r < tab_pct + 35 || lo > hi) code = 8'($urandom_range(0, 255));
      else code = 8'($urandom_range(lo, hi));
      add_char(code, $urandom_range(0, 29) == 0);
      if ($urandom_range(0, 59) == 0) add_pause(0);
    end
  endtask

  // Q8.8 or Q0.16 field: usually modest, sometimes anything
  function automatic logic [15:0] pick16(input int modest);
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, modest));
  endfunction

  initial begin : plan
    int ph, first_c, last_c, per_row_c, tabs_c, swap_c;
    logic [31:0] cm, lim;
    logic [63:0] gb, ac;
    int k;

    // Reset settings: zero sizes, so v_low clamps at the top of the atlas
    add_char("A", 1'b1);
    add_char("B", 1'b0);
    add_char(mfgql_pkg::CODE_SPACE, 1'b0);
    add_char(mfgql_pkg::CODE_TAB, 1'b0);
    add_char(mfgql_pkg::CODE_CR, 1'b0);
    add_char(mfgql_pkg::CODE_LF, 1'b0);
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b0);
    add_char(8'h7E, 1'b0);

    // Full code range: controls still act as controls; narrow wrap limit
    program_all({8'd3, 8'd16, 8'hFF, 8'h00}, 64'h0200_0100_1000_0800,
                {32'h0000_2000, 16'h0600}, 32'h0200_0100, 64'h0020_0010_1A00_0F00);
    add_char(8'h00, 1'b1);
    add_char(8'hFF, 1'b0);
    add_char("a", 1'b0);
    add_char(mfgql_pkg::CODE_TAB, 1'b0);
    add_char(mfgql_pkg::CODE_CR, 1'b0);
    add_char(mfgql_pkg::CODE_LF, 1'b0);
    add_char(mfgql_pkg::CODE_SPACE, 1'b0);
    for (k = 0; k < 5; k++) add_char("A", 1'b0);

    // Zero glyphs per row, zero tab count
    program_all({8'd0, 8'd0, 8'hFF, 8'h30}, 64'h0100_0080_0C00_0600,
                {32'h0, 16'h0400}, 32'h0000_0800, 64'h0004_0002_0800_0100);
    add_char("z", 1'b1);
    add_char(8'hFF, 1'b0);
    add_char(mfgql_pkg::CODE_TAB, 1'b0);
    add_char(8'h2F, 1'b0);

    // Empty range: everything but the controls is a space
    program_all({8'd2, 8'd8, 8'h10, 8'h80}, 64'h0100_0100_1000_0800,
                {32'h0, 16'h0500}, 32'h0, 64'h0);
    add_char("A", 1'b0);
    add_char(8'h90, 1'b0);
    add_char(8'h00, 1'b0);
    add_char(mfgql_pkg::CODE_TAB, 1'b0);

    // All ones: maximum sizes, uv saturation and v clamped to zero
    cm = {8'd1, 8'd255, 8'hFF, 8'h00};
    program_all(cm, '1, '1, '1, '1);
    add_text(40, cm, 5);

    // Long tabs at maximum advance: pen x saturates, x_right clips
    cm = {8'd255, 8'd16, 8'h7E, 8'h21};
    program_all(cm, '1, {32'hFFFF_FFFF, 16'hFFFF}, 32'($urandom), 64'h0010_0008_0400_0300);
    add_text(70, cm, 40);

    // Limit of one: every tab stop wraps, pen y saturates low
    program_all(cm, '1, {32'h0000_0001, 16'hFFFF}, 32'($urandom), 64'h0010_0008_0400_0300);
    for (k = 1; k <= 3; k++)
      add_reg(3'(mfgql_pkg::CFG_ATLAS_CELL + k), {$urandom, $urandom});
    add_text(70, cm, 40);

    // Random register sets; the last one runs without any idling
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      first_c = $urandom_range(0, 96);
      last_c = first_c + $urandom_range(0, 159);
      if (last_c > 255) last_c = 255;
      if ($urandom_range(0, 5) == 0) begin
        swap_c = first_c;
        first_c = last_c;
        last_c = swap_c;
      end
      per_row_c = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 255);
      tabs_c = $urandom_range(0, 6);
      cm = {8'(tabs_c), 8'(per_row_c), 8'(last_c), 8'(first_c)};
      gb = {pick16(16'h0400), pick16(16'h0200), pick16(16'h1800), pick16(16'h1000)};
      case ($urandom_range(0, 3))
        0: lim = '0;
        1: lim = $urandom;
        default: lim = $urandom_range(256, 32'h0004_0000);
      endcase
      ac = {pick16(16'h0100), pick16(16'h0100), pick16(16'h1000), pick16(16'h1000)};
      if (ph == RANDOM_PHASES - 1) calm_fill = 1'b1;
      program_all(cm, gb, {lim, pick16(16'h1000)}, $urandom, ac);
      add_text(80, cm, 5);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (feed_done && due_count == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (quads_due.size() != 0) begin
      fails += quads_due.size();
      $display("%0d predicted quads never came out", quads_due.size());
    end
    $display("Summary: %0d characters sent, %0d quads checked, %0d register sets",
             chars_done, quads_seen, settings_used);
    $display("Covered tabs, wrap, empty range, pen and uv saturation; %0d mismatches",
             fails);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
